>>> rtl/core/gf2_quadratic_exponential_sum_top_defines.svh
// Assertion macros used by the checker file of the quadratic exponential sum block.
`ifndef GF2_QUADRATIC_EXPONENTIAL_SUM_TOP_DEFINES_SVH
`define GF2_QUADRATIC_EXPONENTIAL_SUM_TOP_DEFINES_SVH

// Same-cycle implication, checked on every rising clock outside reset.
`define GF2QES_ASSERT_NOW(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, checked on every rising clock outside reset.
`define GF2QES_ASSERT_NEXT(label, ante, cons, msg) \
	label: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

>>> rtl/core/gf2qes_pkg.sv
// Shared widths, codes and status type of the quadratic exponential sum block.
package gf2qes_pkg;

	localparam int MAX_VARS_DEF = 64;
	localparam int SIZE_RESET   = 32;
	localparam int SIZE_W       = 7;
	localparam int HALV_W       = 7;
	localparam int IDX_W        = 6;
	localparam int ROW_W        = 64;
	localparam int SIGN_W       = 2;
	localparam int EXP_W        = 7;

	localparam logic [SIGN_W-1:0] SIGN_ZERO = 2'b00;
	localparam logic [SIGN_W-1:0] SIGN_POS  = 2'b01;
	localparam logic [SIGN_W-1:0] SIGN_NEG  = 2'b11;

	typedef struct packed {
		logic              done;
		logic              zero;
		logic              neg;
		logic [HALV_W-1:0] halv;
	} stat_t;

endpackage

>>> rtl/core/gf2qes_core.sv
// Row store, working matrix and elimination sequencer of the quadratic exponential sum.
module gf2qes_core #(
	parameter int MAX_VARS = gf2qes_pkg::MAX_VARS_DEF
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic [gf2qes_pkg::SIZE_W-1:0] size,
	input  logic                          go,
	input  logic                          ld_en,
	input  logic [$clog2(MAX_VARS)-1:0]   ld_idx,
	input  logic [MAX_VARS-1:0]           ld_row,
	input  logic                          ld_lin,
	output logic                          busy,
	output gf2qes_pkg::stat_t             stat
);

	localparam int AW = $clog2(MAX_VARS);
	localparam int SW = gf2qes_pkg::SIZE_W;
	localparam int HW = gf2qes_pkg::HALV_W;

	typedef enum logic [8:0] {
		ST_IDLE  = 9'b000000001,
		ST_COPY  = 9'b000000010,
		ST_PICK  = 9'b000000100,
		ST_GATHP = 9'b000001000,
		ST_DECIDE = 9'b000010000,
		ST_GATHM = 9'b000100000,
		ST_PAIR  = 9'b001000000,
		ST_UPD   = 9'b010000000,
		ST_DONE  = 9'b100000000
	} state_t;

	state_t state_q;

	logic [MAX_VARS-1:0] store_mem [MAX_VARS];
	logic [MAX_VARS-1:0] work_mem  [MAX_VARS];
	logic [MAX_VARS-1:0] store_rd_q, work_rd_q;
	logic [MAX_VARS-1:0] linvec_q;

	logic [MAX_VARS-1:0] lin_q, act_q, rowp_q, colp_q, rowm_q, colm_q;
	logic [AW-1:0]       piv_q, mate_q, rdi_q;
	logic [SW-1:0]       cnt_q, cnt_d;
	logic [HW-1:0]       halv_q;
	logic                rdv_q, flag_q, zero_q, lin_p_q;

	logic [MAX_VARS-1:0] vmask, bp, cm, cp, pbit, mbit, enc_in, wr_data;
	logic [AW-1:0]       rd_addr, enc_idx;
	logic                sweep, rd_en, sweep_end, lin_p, lin_m, wr_en;

	// Mask of variables in use
	always_comb begin
		for (int i = 0; i < MAX_VARS; i++) begin
			vmask[i] = (SW'(i) < size);
		end
	end

	// Sweep control: one row read per cycle, data back in the next cycle
	assign sweep     = (state_q == ST_COPY) || (state_q == ST_GATHP) ||
	                   (state_q == ST_GATHM) || (state_q == ST_UPD);
	assign rd_en     = sweep && (cnt_q < size);
	assign sweep_end = (cnt_q == size) && !rdv_q;
	assign rd_addr   = cnt_q[AW-1:0];

	// Pivot and mate one-hot bits
	assign pbit = {{(MAX_VARS-1){1'b0}}, 1'b1} << piv_q;
	assign mbit = {{(MAX_VARS-1){1'b0}}, 1'b1} << mate_q;

	// Symmetric couplings of the pivot and of the mate, masked to live variables
	assign bp    = (rowp_q ^ colp_q) & act_q;
	assign cm    = (rowm_q ^ colm_q) & act_q & ~pbit & ~mbit;
	assign cp    = colp_q & ~mbit;
	assign lin_p = lin_q[piv_q] ^ rowp_q[piv_q];
	assign lin_m = lin_q[mate_q] ^ rowm_q[mate_q];

	// Lowest set bit: live variables when picking, pivot couplings otherwise
	assign enc_in = (state_q == ST_PICK) ? act_q : bp;
	always_comb begin
		enc_idx = '0;
		for (int i = MAX_VARS - 1; i >= 0; i--) begin
			if (enc_in[i]) begin
				enc_idx = AW'(i);
			end
		end
	end

	// Working matrix write: copy in, or rank-two update of coupled rows
	assign wr_en   = rdv_q && ((state_q == ST_COPY) || ((state_q == ST_UPD) && colm_q[rdi_q]));
	assign wr_data = (state_q == ST_COPY) ? (store_rd_q & vmask) : (work_rd_q ^ colp_q);

	// Sweep counter
	always_comb begin
		cnt_d = cnt_q;
		if (rd_en) begin
			cnt_d = cnt_q + SW'(1);
		end else if ((state_q == ST_IDLE) || (state_q == ST_PICK) ||
		             (state_q == ST_DECIDE) || (state_q == ST_PAIR)) begin
			cnt_d = '0;
		end
	end

	// Row store and linear vector, written on load
	always_ff @(posedge clk) begin
		if (ld_en) begin
			store_mem[ld_idx] <= ld_row;
			linvec_q[ld_idx]  <= ld_lin;
		end
		store_rd_q <= store_mem[rd_addr];
	end

	// Working matrix
	always_ff @(posedge clk) begin
		if (wr_en) begin
			work_mem[rdi_q] <= wr_data;
		end
		work_rd_q <= work_mem[rd_addr];
	end

	// Sequencer
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
			rdv_q   <= 1'b0;
		end else begin
			cnt_q <= cnt_d;
			rdv_q <= rd_en;
			case (state_q)
				ST_IDLE: begin
					if (go) state_q <= ST_COPY;
				end
				ST_COPY: begin
					if (sweep_end) state_q <= ST_PICK;
				end
				ST_PICK: begin
					state_q <= (act_q == '0) ? ST_DONE : ST_GATHP;
				end
				ST_GATHP: begin
					if (sweep_end) state_q <= ST_DECIDE;
				end
				ST_DECIDE: begin
					if (bp != '0) state_q <= ST_GATHM;
					else          state_q <= lin_p ? ST_DONE : ST_PICK;
				end
				ST_GATHM: begin
					if (sweep_end) state_q <= ST_PAIR;
				end
				ST_PAIR: begin
					state_q <= ST_UPD;
				end
				ST_UPD: begin
					if (sweep_end) state_q <= ST_PICK;
				end
				ST_DONE: begin
					state_q <= ST_IDLE;
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// Elimination datapath
	always_ff @(posedge clk) begin
		rdi_q <= rd_addr;
		case (state_q)
			ST_COPY: begin
				// set up the working registers on the first copy cycle
				if (cnt_q == '0) begin
					lin_q  <= linvec_q & vmask;
					act_q  <= vmask;
					halv_q <= '0;
					flag_q <= 1'b0;
					zero_q <= 1'b0;
				end
			end
			ST_PICK: begin
				piv_q <= enc_idx;
			end
			ST_GATHP: begin
				if (rdv_q) begin
					colp_q[rdi_q] <= work_rd_q[piv_q];
					if (rdi_q == piv_q) rowp_q <= work_rd_q;
				end
			end
			ST_DECIDE: begin
				if (bp != '0) begin
					mate_q  <= enc_idx;
					colp_q  <= bp;
					lin_p_q <= lin_p;
				end else if (lin_p) begin
					zero_q <= 1'b1;
				end else begin
					// free variable: drop it, sum doubles
					act_q  <= act_q & ~pbit;
					halv_q <= halv_q + HW'(1);
				end
			end
			ST_GATHM: begin
				if (rdv_q) begin
					colm_q[rdi_q] <= work_rd_q[mate_q];
					if (rdi_q == mate_q) rowm_q <= work_rd_q;
				end
			end
			ST_PAIR: begin
				// sum out the coupled pair
				lin_q  <= lin_q ^ (lin_p_q ? cm : '0) ^ (lin_m ? cp : '0);
				flag_q <= flag_q ^ (lin_p_q & lin_m);
				halv_q <= halv_q + HW'(1);
				act_q  <= act_q & ~pbit & ~mbit;
				colp_q <= cp;
				colm_q <= cm;
			end
			default: begin
			end
		endcase
	end

	assign busy      = (state_q != ST_IDLE);
	assign stat.done = (state_q == ST_DONE);
	assign stat.zero = zero_q;
	assign stat.neg  = flag_q;
	assign stat.halv = halv_q;

endmodule

>>> rtl/core/gf2_quadratic_exponential_sum_top.sv
// Top level of the quadratic exponential sum block: size register, loads, result word.
//
// channel  | handshake              | word
// ---------+------------------------+-------------------------------------------
// input    | start / busy           | row_index, row_bits, linear_bit, last
// config   | cfg_valid / cfg_ready  | size_in_use
// result   | done (one-cycle)       | amplitude_sign, amplitude_exponent
//
// A row word loads while busy is low. A word with last set keeps busy high while the
// row store is copied and variables are eliminated, a free variable alone or a
// coupled pair together; the run time is set by the row sweeps through the single
// read port of the working matrix. done pulses in the first cycle with busy low.
// Reset clears the sequencer and sets size to 32, or to MAX_VARS if smaller; stored
// rows stay undefined until written. The receiver cannot stall.
module gf2_quadratic_exponential_sum_top #(
	parameter int MAX_VARS = gf2qes_pkg::MAX_VARS_DEF
) (
	input  logic                                 clk,
	input  logic                                 arst_n,
	input  logic                                 start,
	output logic                                 busy,
	input  logic [gf2qes_pkg::IDX_W-1:0]         row_index,
	input  logic [gf2qes_pkg::ROW_W-1:0]         row_bits,
	input  logic                                 linear_bit,
	input  logic                                 last,
	input  logic                                 cfg_valid,
	output logic                                 cfg_ready,
	input  logic [gf2qes_pkg::SIZE_W-1:0]        size_in_use,
	output logic                                 done,
	output logic signed [gf2qes_pkg::SIGN_W-1:0] amplitude_sign,
	output logic signed [gf2qes_pkg::EXP_W-1:0]  amplitude_exponent
);

	localparam int AW = $clog2(MAX_VARS);
	localparam int SW = gf2qes_pkg::SIZE_W;
	localparam int RESET_N = (gf2qes_pkg::SIZE_RESET > MAX_VARS) ?
	                         MAX_VARS : gf2qes_pkg::SIZE_RESET;
	localparam logic [SW-1:0] SIZE_MAX = SW'(MAX_VARS);

	logic [SW-1:0]                        size_q;
	logic                                 done_q;
	logic [gf2qes_pkg::SIGN_W-1:0]        sign_q;
	logic [gf2qes_pkg::EXP_W-1:0]         exp_q;
	logic                                 core_busy, accept, ld_en;
	gf2qes_pkg::stat_t                    stat;

	assign accept = start && !core_busy;
	assign ld_en  = accept && ({1'b0, row_index} < SIZE_MAX);

	gf2qes_core #(
		.MAX_VARS(MAX_VARS)
	) u_core (
		.clk    (clk),
		.arst_n (arst_n),
		.size   (size_q),
		.go     (accept && last),
		.ld_en  (ld_en),
		.ld_idx (row_index[AW-1:0]),
		.ld_row (row_bits[MAX_VARS-1:0]),
		.ld_lin (linear_bit),
		.busy   (core_busy),
		.stat   (stat)
	);

	// Size register, clamped to 1..MAX_VARS
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			size_q <= SW'(RESET_N);
		end else if (cfg_valid && cfg_ready) begin
			if (size_in_use == '0)          size_q <= SW'(1);
			else if (size_in_use > SIZE_MAX) size_q <= SIZE_MAX;
			else                             size_q <= size_in_use;
		end
	end

	// Result word: registered on done
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			done_q <= 1'b0;
		end else begin
			done_q <= stat.done;
		end
	end

	always_ff @(posedge clk) begin
		if (stat.done) begin
			if (stat.zero) begin
				sign_q <= gf2qes_pkg::SIGN_ZERO;
				exp_q  <= '0;
			end else begin
				sign_q <= stat.neg ? gf2qes_pkg::SIGN_NEG : gf2qes_pkg::SIGN_POS;
				exp_q  <= stat.halv - size_q;
			end
		end
	end

	assign busy               = core_busy;
	assign cfg_ready          = !core_busy;
	assign done               = done_q;
	assign amplitude_sign     = sign_q;
	assign amplitude_exponent = exp_q;

endmodule

>>> rtl/core/gf2qes_check.sv
// Port checker of the quadratic exponential sum block and its bind to the top level.
`include "gf2_quadratic_exponential_sum_top_defines.svh"

module gf2qes_check (
	input logic                                 clk,
	input logic                                 arst_n,
	input logic                                 start,
	input logic                                 busy,
	input logic                                 last,
	input logic                                 done,
	input logic signed [gf2qes_pkg::SIGN_W-1:0] amplitude_sign,
	input logic signed [gf2qes_pkg::EXP_W-1:0]  amplitude_exponent
);

	logic sign_zero, sign_legal, exp_nonpos;

	// decode the result word
	assign sign_zero  = (amplitude_sign == gf2qes_pkg::SIGN_ZERO);
	assign sign_legal = sign_zero || (amplitude_sign == gf2qes_pkg::SIGN_POS) ||
	                    (amplitude_sign == gf2qes_pkg::SIGN_NEG);
	assign exp_nonpos = amplitude_exponent[gf2qes_pkg::EXP_W-1] || (amplitude_exponent == '0);

	// a last word always starts a computation
	`GF2QES_ASSERT_NEXT(a_last_sets_busy, start && !busy && last, busy, "last word did not start")

	// results come one at a time
	`GF2QES_ASSERT_NEXT(a_done_single, done, !done, "back-to-back results")

	// sign is one of the three legal codes
	`GF2QES_ASSERT_NOW(a_sign_legal, done, sign_legal, "illegal sign code")

	// a zero sum carries a zero exponent
	`GF2QES_ASSERT_NOW(a_zero_exp, done && sign_zero, amplitude_exponent == '0, "zero sum exponent")

	// the exponent never goes positive
	`GF2QES_ASSERT_NOW(a_exp_nonpos, done, exp_nonpos, "positive exponent")

endmodule

bind gf2_quadratic_exponential_sum_top gf2qes_check u_gf2qes_check (
	.clk                (clk),
	.arst_n             (arst_n),
	.start              (start),
	.busy               (busy),
	.last               (last),
	.done               (done),
	.amplitude_sign     (amplitude_sign),
	.amplitude_exponent (amplitude_exponent)
);
